// File: design/mfd_pkg.sv
// Shared types, defaults and the sequencer microcode for the modulated fractional delay.
// No dependencies; imported by modulated_fractional_delay_top.
`default_nettype none

package mfd_pkg;

  // Parameter defaults
  localparam int BUFFER_DEPTH_DEF     = 16384;
  localparam int UPDATE_INTERVAL_DEF  = 8;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  // Field widths fixed by the interface
  localparam int SAMPLE_W = 24;
  localparam int BASE_W   = 14;
  localparam int DEPTH_W  = 30;
  localparam int PHASE_W  = 24;
  localparam int FRAC_W   = 16;
  localparam int COUNT_W  = 4;
  localparam int SINE_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_RATE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE = 8'd3;

  // Q62 constants for the sine table build
  localparam logic [63:0] Q62_ONE     = 64'h4000000000000000;
  localparam logic [63:0] Q62_HALF_PI = 64'h6487ED5110B4611A;

  // Micro-operations of the datapath
  typedef enum logic [3:0] {
    UOP_CHECK,   // test whether the LFO is due
    UOP_PHASE,   // advance the LFO phase
    UOP_INDEX,   // scale phase to a table address
    UOP_SINE,    // registered sine table read
    UOP_DEPTH,   // depth times sine
    UOP_TOTAL,   // add base delay, clamp
    UOP_TAP,     // tap pointer and fraction
    UOP_WRITE,   // store the new sample
    UOP_READ_A,  // read the nearer tap
    UOP_READ_B,  // read the farther tap, hold the nearer one
    UOP_MUL_A,   // nearer tap times its gain
    UOP_MUL_B,   // accumulate farther tap times fraction
    UOP_EMIT     // round, saturate, load the output register
  } uop_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    uop_t  op;
    logic  skip_fresh;  // jump to target when no LFO update is due
    step_t target;
  } ucode_t;

  localparam step_t STEP_WRITE = 4'd7;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Control program: one word per step
  function automatic ucode_t ucode_word(input step_t s);
    ucode_t w;
    w = '{op: UOP_EMIT, skip_fresh: 1'b0, target: '0};
    unique case (s)
      4'd0:    w = '{op: UOP_CHECK,  skip_fresh: 1'b1, target: STEP_WRITE};
      4'd1:    w.op = UOP_PHASE;
      4'd2:    w.op = UOP_INDEX;
      4'd3:    w.op = UOP_SINE;
      4'd4:    w.op = UOP_DEPTH;
      4'd5:    w.op = UOP_TOTAL;
      4'd6:    w.op = UOP_TAP;
      4'd7:    w.op = UOP_WRITE;
      4'd8:    w.op = UOP_READ_A;
      4'd9:    w.op = UOP_READ_B;
      4'd10:   w.op = UOP_MUL_A;
      4'd11:   w.op = UOP_MUL_B;
      4'd12:   w.op = UOP_EMIT;
      default: w.op = UOP_EMIT;
    endcase
    return w;
  endfunction

  // Q62 product of two Q62 values (bits 125:62 of the full 128-bit product)
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

endpackage

`default_nettype wire

// File: design/modulated_fractional_delay_top.sv
// Modulated fractional delay line: microcoded sequencer, circular sample store, sine ROM.
// Depends on mfd_pkg for types, microcode and defaults.
// Flow: one sample at a time; a new input is taken only once the step program has emitted the last
//   result, and the emit step waits while the output register is full and not taken. LFO refresh
//   samples (every UPDATE_INTERVAL samples) run the longer step program through the single store port.
// Reset: synchronous; clears control, pointers and LFO state. The store needs no clearing
//   pass: a fill flag makes entries not yet written since reset read as zero.
`default_nettype none

module modulated_fractional_delay_top #(
  parameter int BUFFER_DEPTH     = mfd_pkg::BUFFER_DEPTH_DEF,
  parameter int UPDATE_INTERVAL  = mfd_pkg::UPDATE_INTERVAL_DEF,
  parameter int SINE_TABLE_DEPTH = mfd_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [mfd_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [23:0] in_sample
  // Output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [mfd_pkg::SAMPLE_W-1:0]         m_axis_tdata,   // [23:0] out_sample
  // Configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import mfd_pkg::*;

  localparam int PTR_W   = $clog2(BUFFER_DEPTH);
  localparam int SIN_AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_PW  = PHASE_W + $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TOTAL_W = 35;
  localparam int ACC_W   = 42;

  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [PTR_W-1:0]   PTR_DEPTH = PTR_W'(BUFFER_DEPTH);
  localparam logic [COUNT_W-1:0] UPD_LIMIT = COUNT_W'(UPDATE_INTERVAL);
  localparam logic signed [TOTAL_W-1:0] TOTAL_TOP =
    TOTAL_W'(longint'(BUFFER_DEPTH - 2) * 65536);
  localparam logic [63:0] HALF_PI_STEP = Q62_HALF_PI / SINE_TABLE_DEPTH;
  localparam logic [63:0] HALF_PI_REM  = Q62_HALF_PI % SINE_TABLE_DEPTH;

  // Sine table entry: round(32767*sin(2*pi*i/depth)) built in Q62 at elaboration
  function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] inner;
    logic [63:0] s;
    logic [63:0] v;
    q = 64'((4 * i) / SINE_TABLE_DEPTH);
    r = 64'((4 * i) % SINE_TABLE_DEPTH);
    x = HALF_PI_STEP * r + (HALF_PI_REM * r) / SINE_TABLE_DEPTH;
    if (q[0]) begin
      x = Q62_HALF_PI - x;
    end
    x2 = mul_q62(x, x);
    inner = Q62_ONE;
    for (int k = 16; k >= 2; k -= 2) begin
      inner = Q62_ONE - mul_q62(x2, inner) / 64'(k * (k + 1));
    end
    s = mul_q62(x, inner);
    v = ((s >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
    if (q >= 64'd2) begin
      return -$signed(SINE_W'(v));
    end
    return $signed(SINE_W'(v));
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BASE_W-1:0]  base_delay;
  logic [DEPTH_W-1:0] mod_depth;
  logic [PHASE_W-1:0] mod_rate;
  logic               cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  seq_state_t state, state_next;
  step_t      step;
  ucode_t     uw;
  logic       in_xfer;
  logic       emit_ok;
  logic       upd_due;
  logic       out_valid;

  logic [COUNT_W-1:0] upd_cnt;

  assign uw            = ucode_word(step);
  assign s_axis_tready = (state == SEQ_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign emit_ok       = ~out_valid | m_axis_tready;
  assign upd_due       = (upd_cnt >= UPD_LIMIT);

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (in_xfer) state_next = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (uw.op == UOP_EMIT && emit_ok) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        step <= '0;
      end else if (state == SEQ_RUN && uw.op != UOP_EMIT) begin
        if (uw.skip_fresh && !upd_due) begin
          step <= uw.target;
        end else begin
          step <= step + 4'd1;
        end
      end
    end
  end

  // Decode the control word into datapath strobes
  logic run;
  logic do_phase, do_index, do_sine, do_depth, do_total, do_tap;
  logic do_write, do_read_a, do_read_b, do_mul_a, do_mul_b, do_emit;

  always_comb begin
    run       = (state == SEQ_RUN);
    do_phase  = 1'b0;
    do_index  = 1'b0;
    do_sine   = 1'b0;
    do_depth  = 1'b0;
    do_total  = 1'b0;
    do_tap    = 1'b0;
    do_write  = 1'b0;
    do_read_a = 1'b0;
    do_read_b = 1'b0;
    do_mul_a  = 1'b0;
    do_mul_b  = 1'b0;
    do_emit   = 1'b0;
    if (run) begin
      unique case (uw.op)
        UOP_CHECK:  ;
        UOP_PHASE:  do_phase  = 1'b1;
        UOP_INDEX:  do_index  = 1'b1;
        UOP_SINE:   do_sine   = 1'b1;
        UOP_DEPTH:  do_depth  = 1'b1;
        UOP_TOTAL:  do_total  = 1'b1;
        UOP_TAP:    do_tap    = 1'b1;
        UOP_WRITE:  do_write  = 1'b1;
        UOP_READ_A: do_read_a = 1'b1;
        UOP_READ_B: do_read_b = 1'b1;
        UOP_MUL_A:  do_mul_a  = 1'b1;
        UOP_MUL_B:  do_mul_b  = 1'b1;
        UOP_EMIT:   do_emit   = emit_ok;
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // LFO path: phase, table address, sine, depth scaling, clamped total delay
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]           lfo_phase;
  logic [PHASE_W+COUNT_W-1:0]   phase_step;
  logic [IDX_PW-1:0]            idx_prod;
  logic [SIN_AW-1:0]            sine_idx;
  logic signed [SINE_W-1:0]     sine_q;
  logic signed [46:0]           depth_prod;
  logic signed [47:0]           offset_sum;
  logic signed [32:0]           offset;
  logic signed [TOTAL_W-1:0]    total_sum;
  logic [PTR_W+FRAC_W-1:0]      total_q;
  logic [PTR_W-1:0]             whole;
  logic [PTR_W:0]               tap_diff;
  logic [PTR_W-1:0]             write_pointer;
  logic [PTR_W-1:0]             tap_pointer;
  logic [FRAC_W-1:0]            tap_fraction;
  logic signed [SINE_W-1:0]     sine_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
    assign sine_rom[g] = sine_entry(g);
  end

  assign phase_step = mod_rate * COUNT_W'(UPDATE_INTERVAL);
  assign idx_prod   = IDX_PW'(lfo_phase) * IDX_PW'(SINE_TABLE_DEPTH);
  // floor((depth*sine + 16384) / 32768)
  assign offset_sum = 48'(depth_prod) + 48'sd16384;
  assign offset     = offset_sum[47:15];
  assign total_sum  = $signed({5'b0, base_delay, 16'b0}) + TOTAL_W'(offset);
  assign whole      = total_q[FRAC_W +: PTR_W];
  assign tap_diff   = {1'b0, write_pointer} - {1'b0, whole};

  // Sine ROM, registered read
  always_ff @(posedge clk) begin
    if (do_sine) begin
      sine_q <= sine_rom[sine_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (do_index) begin
      sine_idx <= idx_prod[PHASE_W +: SIN_AW];
    end
    if (do_depth) begin
      depth_prod <= $signed({1'b0, mod_depth}) * sine_q;
    end
    if (do_total) begin
      // clamp to 0..BUFFER_DEPTH-2 samples
      if (total_sum < 0) begin
        total_q <= '0;
      end else if (total_sum > TOTAL_TOP) begin
        total_q <= (PTR_W+FRAC_W)'(TOTAL_TOP);
      end else begin
        total_q <= total_sum[PTR_W+FRAC_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Circular store with fill flag
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0]            tap_b;
  logic [PTR_W-1:0]            rd_addr;
  logic                        rd_en;
  logic                        store_full;
  logic signed [SAMPLE_W-1:0]  sample_q;
  logic signed [SAMPLE_W-1:0]  rd_q;
  logic                        rd_ok;
  logic signed [SAMPLE_W-1:0]  store [BUFFER_DEPTH];

  assign tap_b   = (tap_pointer == '0) ? PTR_LAST : tap_pointer - PTR_W'(1);
  assign rd_addr = do_read_b ? tap_b : tap_pointer;
  assign rd_en   = do_read_a | do_read_b;

  always_ff @(posedge clk) begin
    if (do_write) begin
      store[write_pointer] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_q <= $signed(s_axis_tdata);
    end
    // entries above the write pointer are unwritten until the first wrap
    if (rd_en) begin
      rd_ok <= store_full | (rd_addr <= write_pointer);
    end
  end

  // ---------------------------------------------------------------------------
  // Interpolation: shared multiplier, accumulate, round and saturate
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0]  a_q;
  logic signed [SAMPLE_W-1:0]  b_val;
  logic [FRAC_W:0]             gain_a;
  logic signed [SAMPLE_W-1:0]  mul_x;
  logic signed [FRAC_W+1:0]    mul_y;
  logic signed [ACC_W-1:0]     mul_p;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_rnd;
  logic signed [25:0]          y_full;
  logic signed [SAMPLE_W-1:0]  y_sat;
  logic [SAMPLE_W-1:0]         out_sample;

  assign b_val   = rd_ok ? rd_q : '0;
  assign gain_a  = 17'h10000 - {1'b0, tap_fraction};
  assign mul_x   = do_mul_a ? a_q : b_val;
  assign mul_y   = do_mul_a ? $signed({1'b0, gain_a}) : $signed({2'b0, tap_fraction});
  assign mul_p   = mul_x * mul_y;
  assign acc_rnd = acc + 42'sd32768;
  assign y_full  = acc_rnd[ACC_W-1:16];

  always_comb begin
    if (y_full > 26'sd8388607) begin
      y_sat = 24'sh7FFFFF;
    end else if (y_full < -26'sd8388608) begin
      y_sat = -24'sh800000;
    end else begin
      y_sat = y_full[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (do_read_b) begin
      a_q <= b_val;
    end
    if (do_mul_a) begin
      acc <= mul_p;
    end else if (do_mul_b) begin
      acc <= acc + mul_p;
    end
    if (do_emit) begin
      out_sample <= y_sat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sample;

  // ---------------------------------------------------------------------------
  // Control state: config, pointers, LFO phase, update counter, output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay    <= '0;
      mod_depth     <= '0;
      mod_rate      <= '0;
      lfo_phase     <= '0;
      upd_cnt       <= UPD_LIMIT;
      write_pointer <= '0;
      tap_pointer   <= '0;
      tap_fraction  <= '0;
      store_full    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        unique case (cfg_index)
          CFG_BASE_DELAY:  base_delay <= cfg_data[BASE_W-1:0];
          CFG_MOD_DEPTH:   mod_depth  <= cfg_data[DEPTH_W-1:0];
          CFG_MOD_RATE:    mod_rate   <= cfg_data[PHASE_W-1:0];
          CFG_START_PHASE: begin
            // load the phase and force a refresh on the next sample
            lfo_phase   <= cfg_data[PHASE_W-1:0];
            upd_cnt     <= UPD_LIMIT;
          end
          default: ;
        endcase
      end

      if (do_phase) begin
        lfo_phase <= lfo_phase + phase_step[PHASE_W-1:0];
      end

      if (do_tap) begin
        tap_pointer  <= tap_diff[PTR_W] ? tap_diff[PTR_W-1:0] + PTR_DEPTH
                                        : tap_diff[PTR_W-1:0];
        tap_fraction <= total_q[FRAC_W-1:0];
        upd_cnt      <= '0;
      end

      if (do_emit) begin
        out_valid     <= 1'b1;
        // advance both pointers and the refresh counter
        write_pointer <= (write_pointer == PTR_LAST) ? '0 : write_pointer + PTR_W'(1);
        if (write_pointer == PTR_LAST) begin
          store_full <= 1'b1;
        end
        tap_pointer   <= (tap_pointer == PTR_LAST) ? '0 : tap_pointer + PTR_W'(1);
        upd_cnt       <= upd_cnt + COUNT_W'(1);
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
